FILE: rtl/core/srl_pkg.sv
// ----------------------------------------------------------------------------
// S-record stream loader package
// Shared request types, status codes and sizing constants for the loader core.
// ----------------------------------------------------------------------------
package srl_pkg;

    // Default depth of the result queue; at least two entries are required.
    localparam int RESULT_DEPTH = 4;

    // Sticky error codes and the status reported for an empty record.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_FORMAT   = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_CLEARED   = 2'd3;

    // Kinds of result request.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One character request of an S-record, or the end mark of the record.
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_record;
    } t_char_item;

    // One result request: a memory byte write or a record status.
    typedef struct packed {
        logic        kind;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic [1:0]  status;
        logic [31:0] start_address;
        logic        last;
    } t_result_item;

    // Up to two results produced by one accepted character, in order.
    typedef struct packed {
        logic [1:0]   count;
        t_result_item first;
        t_result_item second;
    } t_result_push;

endpackage

FILE: rtl/core/srl_stream_if.sv
// ----------------------------------------------------------------------------
// S-record stream channel
// Valid/ready channel carrying one request payload per handshake.
// ----------------------------------------------------------------------------
interface srl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

FILE: rtl/core/srl_parser.sv
// ----------------------------------------------------------------------------
// S-record parser
// Record state registers and the per-character decode step.
// ----------------------------------------------------------------------------
module srl_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  srl_pkg::t_char_item  i_item,
    output srl_pkg::t_result_push o_push
);

    localparam logic [2:0] PH_TYPE  = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CKSUM = 3'd4;
    localparam logic [2:0] PH_SKIP  = 3'd5;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_FOUR    = 8'h34;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;

    localparam logic [3:0] DIGITS_SHORT  = 4'd4;
    localparam logic [3:0] DIGITS_MEDIUM = 4'd6;
    localparam logic [3:0] DIGITS_LONG   = 4'd8;

    logic [2:0]  r_phase,        n_phase;
    logic [3:0]  r_record_type,  n_record_type;
    logic [7:0]  r_bytes_left,   n_bytes_left;
    logic [3:0]  r_digit_count,  n_digit_count;
    logic [31:0] r_field_value,  n_field_value;
    logic [31:0] r_load_address, n_load_address;
    logic [7:0]  r_running_sum,  n_running_sum;
    logic [1:0]  r_error_code,   n_error_code;
    logic [31:0] r_exec_address, n_exec_address;

    logic                  hex_ok;
    logic [3:0]            hex_val;
    logic [31:0]           shifted;
    logic [3:0]            digit_inc;
    logic [7:0]            bytes_dec;
    logic [3:0]            addr_digits;
    logic [7:0]            addr_sum;
    logic                  write_valid;
    logic                  status_valid;
    logic                  status_cleared;
    srl_pkg::t_result_item write_item;
    srl_pkg::t_result_item status_item;

    // Hex digit decode of the incoming character.
    always_comb begin
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (i_item.ch >= CHAR_ZERO && i_item.ch <= CHAR_NINE) begin
            hex_ok  = 1'b1;
            hex_val = i_item.ch[3:0];
        end else if (i_item.ch >= CHAR_LOWER_A && i_item.ch <= CHAR_LOWER_F) begin
            hex_ok  = 1'b1;
            hex_val = 4'(i_item.ch - CHAR_LOWER_A + 8'd10);
        end else if (i_item.ch >= CHAR_UPPER_A && i_item.ch <= CHAR_UPPER_F) begin
            hex_ok  = 1'b1;
            hex_val = 4'(i_item.ch - CHAR_UPPER_A + 8'd10);
        end
    end

    assign shifted   = {r_field_value[27:0], hex_val};
    assign digit_inc = r_digit_count + 4'd1;
    assign bytes_dec = r_bytes_left - 8'd1;
    assign addr_sum  = r_running_sum + shifted[7:0] + shifted[15:8]
                     + shifted[23:16] + shifted[31:24];

    always_comb begin
        case (r_record_type)
            4'd1, 4'd9: addr_digits = DIGITS_SHORT;
            4'd2, 4'd8: addr_digits = DIGITS_MEDIUM;
            default:    addr_digits = DIGITS_LONG;
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_record_type  = r_record_type;
        n_bytes_left   = r_bytes_left;
        n_digit_count  = r_digit_count;
        n_field_value  = r_field_value;
        n_load_address = r_load_address;
        n_running_sum  = r_running_sum;
        n_error_code   = r_error_code;
        n_exec_address = r_exec_address;

        write_valid    = 1'b0;
        status_valid   = 1'b0;
        status_cleared = 1'b0;

        write_item               = '0;
        write_item.kind          = srl_pkg::KIND_WRITE;
        write_item.write_address = r_load_address;
        write_item.write_data    = shifted[7:0];
        write_item.status        = r_error_code;
        write_item.start_address = r_exec_address;
        write_item.last          = 1'b1;

        if (i_item.end_of_record) begin
            status_valid = 1'b1;
            case (r_phase)
                PH_TYPE: begin
                    n_error_code   = srl_pkg::ERR_NONE;
                    status_cleared = 1'b1;
                end
                PH_COUNT, PH_ADDR: begin
                    n_error_code = srl_pkg::ERR_FORMAT;
                end
                PH_DATA: begin
                    if (r_digit_count != 4'd0) begin
                        // A byte cut off after one digit still counts.
                        if (bytes_dec != 8'd0) begin
                            write_valid           = 1'b1;
                            write_item.write_data = r_field_value[7:0];
                            write_item.last       = 1'b0;
                            n_error_code          = srl_pkg::ERR_FORMAT;
                        end else if (r_running_sum != ~r_field_value[7:0]) begin
                            n_error_code = srl_pkg::ERR_CHECKSUM;
                        end
                    end else begin
                        n_error_code = srl_pkg::ERR_FORMAT;
                    end
                end
                PH_CKSUM: begin
                    if (r_digit_count == 4'd0) begin
                        n_error_code = srl_pkg::ERR_FORMAT;
                    end else if (r_running_sum != ~r_field_value[7:0]) begin
                        n_error_code = srl_pkg::ERR_CHECKSUM;
                    end
                end
                default: begin
                end
            endcase
            n_phase        = PH_TYPE;
            n_record_type  = 4'd0;
            n_bytes_left   = 8'd0;
            n_digit_count  = 4'd0;
            n_field_value  = 32'd0;
            n_load_address = 32'd0;
            n_running_sum  = 8'd0;
        end else begin
            case (r_phase)
                PH_TYPE: begin
                    if (i_item.ch >= CHAR_ZERO && i_item.ch <= CHAR_NINE
                        && i_item.ch != CHAR_FOUR) begin
                        n_record_type = i_item.ch[3:0];
                        if (i_item.ch[3:0] == 4'd0 || i_item.ch[3:0] == 4'd5
                            || i_item.ch[3:0] == 4'd6) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_COUNT;
                        end
                    end else begin
                        n_error_code = srl_pkg::ERR_FORMAT;
                        n_phase      = PH_SKIP;
                    end
                    n_digit_count = 4'd0;
                    n_field_value = 32'd0;
                end
                PH_SKIP: begin
                end
                default: begin
                    if (!hex_ok) begin
                        n_error_code = srl_pkg::ERR_FORMAT;
                        n_phase      = PH_SKIP;
                    end else begin
                        n_field_value = shifted;
                        n_digit_count = digit_inc;
                        case (r_phase)
                            PH_COUNT: begin
                                if (digit_inc == 4'd2) begin
                                    n_bytes_left  = shifted[7:0];
                                    n_running_sum = shifted[7:0];
                                    n_digit_count = 4'd0;
                                    n_field_value = 32'd0;
                                    n_phase       = PH_ADDR;
                                end
                            end
                            PH_ADDR: begin
                                if (digit_inc >= addr_digits) begin
                                    n_running_sum = addr_sum;
                                    n_digit_count = 4'd0;
                                    n_field_value = 32'd0;
                                    if (r_record_type >= 4'd7) begin
                                        n_exec_address = shifted;
                                        n_phase        = PH_CKSUM;
                                    end else begin
                                        n_load_address = shifted;
                                        n_bytes_left   = r_bytes_left
                                                       - 8'(addr_digits >> 1);
                                        n_phase = (n_bytes_left == 8'd0) ? PH_SKIP
                                                                         : PH_DATA;
                                    end
                                end
                            end
                            PH_DATA: begin
                                if (digit_inc == 4'd2) begin
                                    n_bytes_left  = bytes_dec;
                                    n_digit_count = 4'd0;
                                    n_field_value = 32'd0;
                                    if (bytes_dec != 8'd0) begin
                                        write_valid    = 1'b1;
                                        n_load_address = r_load_address + 32'd1;
                                        n_running_sum  = r_running_sum + shifted[7:0];
                                    end else begin
                                        if (r_running_sum != ~shifted[7:0]) begin
                                            n_error_code = srl_pkg::ERR_CHECKSUM;
                                        end
                                        n_phase = PH_SKIP;
                                    end
                                end
                            end
                            PH_CKSUM: begin
                                if (digit_inc == 4'd2) begin
                                    if (r_running_sum != ~shifted[7:0]) begin
                                        n_error_code = srl_pkg::ERR_CHECKSUM;
                                    end
                                    n_phase = PH_SKIP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
        end

        status_item               = '0;
        status_item.kind          = srl_pkg::KIND_STATUS;
        status_item.status        = status_cleared ? srl_pkg::ST_CLEARED : n_error_code;
        status_item.start_address = r_exec_address;
        status_item.last          = 1'b1;
    end

    always_comb begin
        o_push.count  = i_take ? (2'(write_valid) + 2'(status_valid)) : 2'd0;
        o_push.first  = write_valid ? write_item : status_item;
        o_push.second = status_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TYPE;
            r_record_type  <= 4'd0;
            r_bytes_left   <= 8'd0;
            r_digit_count  <= 4'd0;
            r_field_value  <= 32'd0;
            r_load_address <= 32'd0;
            r_running_sum  <= 8'd0;
            r_error_code   <= srl_pkg::ERR_NONE;
            r_exec_address <= 32'd0;
        end else if (i_take) begin
            r_phase        <= n_phase;
            r_record_type  <= n_record_type;
            r_bytes_left   <= n_bytes_left;
            r_digit_count  <= n_digit_count;
            r_field_value  <= n_field_value;
            r_load_address <= n_load_address;
            r_running_sum  <= n_running_sum;
            r_error_code   <= n_error_code;
            r_exec_address <= n_exec_address;
        end
    end

endmodule

FILE: rtl/core/srl_result_fifo.sv
// ----------------------------------------------------------------------------
// S-record result queue
// Small queue taking up to two results a cycle and giving one.
// ----------------------------------------------------------------------------
module srl_result_fifo #(
    parameter int DEPTH = srl_pkg::RESULT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srl_pkg::t_result_push i_push,
    input  logic                  i_pop,
    output srl_pkg::t_result_item o_head,
    output logic                  o_head_valid,
    output logic                  o_room_two
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    srl_pkg::t_result_item r_mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [PTR_W-1:0] wr_ptr_plus;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ptr_plus  = next_ptr(r_wr_ptr);
    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_room_two   = (r_count <= CNT_W'(DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.count == 2'd1) begin
            n_wr_ptr = wr_ptr_plus;
        end else if (i_push.count == 2'd2) begin
            n_wr_ptr = next_ptr(wr_ptr_plus);
        end
        n_rd_ptr = (i_pop && o_head_valid) ? next_ptr(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.count)
                 - CNT_W'(i_pop && o_head_valid);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_plus] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/core/srecord_stream_loader_core.sv
// ----------------------------------------------------------------------------
// S-record stream loader core
// Parses S-record characters into memory byte writes and record status.
// ----------------------------------------------------------------------------
// Each result is registered in the result queue and reaches the output from its head.
// Throughput: one character request per cycle; input ready stays high while the
// result queue has at least two free entries.
// Reset: synchronous, active low; clears the record state, the sticky error,
// the start address and the result queue.
// ----------------------------------------------------------------------------
module srecord_stream_loader_core #(
    parameter int RESULT_DEPTH = srl_pkg::RESULT_DEPTH
) (
    input logic          i_clk,
    input logic          i_rst_n,
    srl_stream_if.sink   i_char,
    srl_stream_if.source o_result
);

    // The parser holds all record state and turns each accepted character into
    // at most two results: a byte write and, at the end mark, a status request.
    // Those results go straight into a small queue, so the parser never waits
    // on the sink while the queue has room for the worst case of two entries.

    srl_pkg::t_result_push push;
    srl_pkg::t_result_item head;
    logic                  head_valid;
    logic                  room_two;
    logic                  take;

    assign i_char.ready = room_two;
    assign take         = i_char.valid && room_two;

    srl_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_char.payload),
        .o_push  (push)
    );

    // The queue's head entry drives the result channel directly; a request
    // leaves the queue at the edge on which the sink takes it.
    srl_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (o_result.ready),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_room_two   (room_two)
    );

    assign o_result.valid   = head_valid;
    assign o_result.payload = head;

endmodule
